/* rtl/core/chd_pkg.sv */
// Shared types, fixed-point constants and the arctangent table of the compass heading block.
package chd_pkg;

  // Field widths
  localparam int MagW  = 16;
  localparam int DeclW = 16;
  localparam int HdgW  = 15;

  // CORDIC datapath: inputs scaled by 2^8, angles in Q30 radians
  localparam int InShift   = 8;
  localparam int XW        = 27;
  localparam int ZW        = 34;
  localparam int SW        = 35;
  localparam int HW        = 33;
  localparam int DeclShift = 17;
  localparam int ProdW     = 65;
  localparam int ScaledW   = 48;

  // Angle constants (Q30)
  localparam logic signed [ZW-1:0] AngPi   = 34'sd3373259426;
  localparam logic signed [ZW-1:0] AngHalf = 34'sd1686629713;
  localparam logic signed [SW-1:0] AngTwoS  = 35'sd6746518852;
  localparam logic signed [SW-1:0] AngFourS = 35'sd13493037704;
  localparam logic [HW-1:0]        AngTwo   = 33'd6746518852;
  localparam logic [63:0]          AngTwo64 = 64'd6746518852;

  // Declination limit (2^-13 rad units)
  localparam logic signed [DeclW-1:0] DeclMax = 16'sd25736;

  // Degree conversion: heading = floor((h * 23040 + pi) / (2 * pi))
  localparam logic [HdgW-1:0] HdgFull  = 15'd23040;
  localparam int              HdgShift = 49;
  localparam logic [63:0]     HdgNum   = 64'd23040 << HdgShift;
  localparam logic [31:0]     HdgRecip = 32'(HdgNum / AngTwo64);

  // One CORDIC transaction in flight
  typedef struct packed {
    logic                 valid;
    logic                 freeze;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  // atan(2^-idx) in Q30, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] val;
    unique case (idx)
      5'd0: val = 34'sd843314857;
      5'd1: val = 34'sd497837829;
      5'd2: val = 34'sd263043837;
      5'd3: val = 34'sd133525159;
      5'd4: val = 34'sd67021687;
      5'd5: val = 34'sd33543516;
      5'd6: val = 34'sd16775851;
      5'd7: val = 34'sd8388437;
      5'd8: val = 34'sd4194283;
      5'd9: val = 34'sd2097149;
      default: begin
        if (idx == 5'd31) begin
          val = 34'sd1;
        end else begin
          val = 34'sd1 <<< (5'd30 - idx);
        end
      end
    endcase
    return val;
  endfunction

endpackage

/* rtl/core/chd_ifs.sv */
// Channel interfaces of the compass heading block: sample, heading result, declination write.
interface chd_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [chd_pkg::MagW-1:0]     mag_x;
  logic signed [chd_pkg::MagW-1:0]     mag_y;
  modport source (output valid, output mag_x, output mag_y, input ready);
  modport sink   (input valid, input mag_x, input mag_y, output ready);
endinterface

interface chd_heading_if;
  logic                      valid;
  logic                      ready;
  logic [chd_pkg::HdgW-1:0]  heading;
  modport source (output valid, output heading, input ready);
  modport sink   (input valid, input heading, output ready);
endinterface

interface chd_decl_if;
  logic                                valid;
  logic                                ready;
  logic signed [chd_pkg::DeclW-1:0]    declination;
  modport source (output valid, output declination, input ready);
  modport sink   (input valid, input declination, output ready);
endinterface

/* rtl/core/chd_front.sv */
// Entry stage: scale the sample, fold the left half plane, resolve exact axes.
module chd_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [chd_pkg::MagW-1:0] mag_x,
  input  logic signed [chd_pkg::MagW-1:0] mag_y,
  output chd_pkg::cord_t                  out_stage
);

  logic signed [chd_pkg::XW-1:0] xs;
  logic signed [chd_pkg::XW-1:0] ys;
  chd_pkg::cord_t                stage_next;

  assign xs = chd_pkg::XW'(mag_x) <<< chd_pkg::InShift;
  assign ys = chd_pkg::XW'(mag_y) <<< chd_pkg::InShift;

  // Pick the starting vector and angle
  always_comb begin
    stage_next.valid  = in_valid;
    stage_next.freeze = 1'b0;
    stage_next.x      = xs;
    stage_next.y      = ys;
    stage_next.z      = '0;
    priority if (mag_y == '0) begin
      stage_next.freeze = 1'b1;
      stage_next.z      = mag_x[chd_pkg::MagW-1] ? chd_pkg::AngPi : '0;
    end else if (mag_x == '0) begin
      stage_next.freeze = 1'b1;
      stage_next.z      = mag_y[chd_pkg::MagW-1] ? -chd_pkg::AngHalf : chd_pkg::AngHalf;
    end else if (mag_x[chd_pkg::MagW-1] && !mag_y[chd_pkg::MagW-1]) begin
      stage_next.x = ys;
      stage_next.y = -xs;
      stage_next.z = chd_pkg::AngHalf;
    end else if (mag_x[chd_pkg::MagW-1]) begin
      stage_next.x = -ys;
      stage_next.y = xs;
      stage_next.z = -chd_pkg::AngHalf;
    end else begin
      stage_next.z = '0;
    end
  end

  // Hold valid under reset, advance payload while enabled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage.valid <= 1'b0;
    end else if (en) begin
      out_stage.valid <= stage_next.valid;
    end
    if (en) begin
      out_stage.freeze <= stage_next.freeze;
      out_stage.x      <= stage_next.x;
      out_stage.y      <= stage_next.y;
      out_stage.z      <= stage_next.z;
    end
  end

endmodule

/* rtl/core/chd_cell.sv */
// One vectoring CORDIC iteration with its own register.
module chd_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  chd_pkg::cord_t in_stage,
  output chd_pkg::cord_t out_stage
);

  localparam logic signed [chd_pkg::ZW-1:0] Angle = chd_pkg::atan_q30(5'(STAGE));

  logic signed [chd_pkg::XW-1:0] xq;
  logic signed [chd_pkg::XW-1:0] yq;
  logic signed [chd_pkg::XW-1:0] dx;
  logic signed [chd_pkg::XW-1:0] dy;
  logic signed [chd_pkg::ZW-1:0] zq;
  logic                          rot_neg;
  logic signed [chd_pkg::XW-1:0] x_next;
  logic signed [chd_pkg::XW-1:0] y_next;
  logic signed [chd_pkg::ZW-1:0] z_next;

  assign xq = in_stage.x;
  assign yq = in_stage.y;
  assign zq = in_stage.z;
  assign dx = yq >>> STAGE;
  assign dy = xq >>> STAGE;
  assign rot_neg = !yq[chd_pkg::XW-1] && (yq != '0);

  // Rotate toward the x axis, or pass a resolved angle through
  always_comb begin
    x_next = xq;
    y_next = yq;
    z_next = zq;
    if (!in_stage.freeze) begin
      if (rot_neg) begin
        x_next = xq + dx;
        y_next = yq - dy;
        z_next = zq + Angle;
      end else begin
        x_next = xq - dx;
        y_next = yq + dy;
        z_next = zq - Angle;
      end
    end
  end

  // Hold valid under reset, advance payload while enabled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_stage.valid <= 1'b0;
    end else if (en) begin
      out_stage.valid <= in_stage.valid;
    end
    if (en) begin
      out_stage.freeze <= in_stage.freeze;
      out_stage.x      <= x_next;
      out_stage.y      <= y_next;
      out_stage.z      <= z_next;
    end
  end

endmodule

/* rtl/core/chd_back.sv */
// Back end: add declination, wrap into one turn, convert radians to 1/64 degree.
module chd_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  chd_pkg::cord_t                   in_stage,
  input  logic signed [chd_pkg::DeclW-1:0] declination,
  output logic                             res_valid,
  output logic [chd_pkg::HdgW-1:0]         res_heading
);

  logic [4:0] vld;

  logic signed [chd_pkg::SW-1:0]      sum1;
  logic signed [chd_pkg::SW-1:0]      sum1_next;
  logic signed [chd_pkg::SW-1:0]      wrap2;
  logic signed [chd_pkg::SW-1:0]      wrap2_next;
  logic [chd_pkg::HW-1:0]             ang3;
  logic [chd_pkg::HW-1:0]             ang3_next;
  logic [chd_pkg::ProdW-1:0]          prod4_full;
  logic [chd_pkg::HdgW-1:0]           est4;
  logic [chd_pkg::ScaledW-1:0]        scaled4;
  logic [chd_pkg::HdgW-1:0]           est5;
  logic [chd_pkg::ScaledW-1:0]        scaled5;
  logic [chd_pkg::ScaledW-1:0]        back5;
  logic signed [chd_pkg::SW-1:0]      ang3_sub;

  // Declination to Q30 and add
  assign sum1_next = chd_pkg::SW'(in_stage.z)
                   + (chd_pkg::SW'(declination) <<< chd_pkg::DeclShift);

  // Lift a negative angle by one turn
  assign wrap2_next = sum1[chd_pkg::SW-1] ? sum1 + chd_pkg::AngTwoS : sum1;

  // Drop one turn above 2*pi, then clamp to [0, 2*pi]
  assign ang3_sub = wrap2 - chd_pkg::AngTwoS;
  always_comb begin
    priority if (wrap2[chd_pkg::SW-1]) begin
      ang3_next = '0;
    end else if (wrap2 > chd_pkg::AngFourS) begin
      ang3_next = chd_pkg::AngTwo;
    end else if (wrap2 > chd_pkg::AngTwoS) begin
      ang3_next = ang3_sub[chd_pkg::HW-1:0];
    end else begin
      ang3_next = wrap2[chd_pkg::HW-1:0];
    end
  end

  // Quotient estimate by reciprocal, never above the rounded result
  assign prod4_full = chd_pkg::ProdW'(ang3) * chd_pkg::ProdW'(chd_pkg::HdgRecip);

  // Round up where the remainder reaches half a turn unit
  always_comb begin
    if ({1'b0, scaled5} >= ({1'b0, back5} + (chd_pkg::ScaledW + 1)'(chd_pkg::AngPi))) begin
      res_heading = est5 + chd_pkg::HdgW'(1);
    end else begin
      res_heading = est5;
    end
  end

  assign res_valid = vld[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_stage.valid};
    end
  end

  // Advance the datapath
  always_ff @(posedge clk) begin
    if (en) begin
      sum1    <= sum1_next;
      wrap2   <= wrap2_next;
      ang3    <= ang3_next;
      est4    <= prod4_full[chd_pkg::HdgShift +: chd_pkg::HdgW];
      scaled4 <= chd_pkg::ScaledW'(ang3) * chd_pkg::ScaledW'(chd_pkg::HdgFull);
      est5    <= est4;
      scaled5 <= scaled4;
      back5   <= chd_pkg::ScaledW'(est4) * chd_pkg::ScaledW'(chd_pkg::AngTwo);
    end
  end

endmodule

/* rtl/core/compass_heading_atan2.sv */
// Top level of the compass heading block: CORDIC cell chain, back end, output and skid registers.
//
//   channel  role     carries                        handshake
//   sample   sink     mag_x, mag_y (signed 16 bit)   valid / ready
//   result   source   heading (unsigned 15 bit)      valid / ready
//   cfg      sink     declination (signed 16 bit)    valid / ready, ready tied high
//
// One transaction per cycle while the skid register is empty. A sample passes the entry stage,
// the chain of CORDIC cells (one iteration each), five back-end stages and the output register.
// The whole pipeline advances together while the skid register is empty.
// A stalled result parks in the skid register; sample.ready drops only while it is full.
// Synchronous reset clears every valid bit and sets declination to 0.
module compass_heading_atan2 #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic              clk,
  input  logic              rst,
  chd_sample_if.sink        sample,
  chd_heading_if.source     result,
  chd_decl_if.sink          cfg
);

  chd_pkg::cord_t chain [CORDIC_STAGES+1];

  logic signed [chd_pkg::DeclW-1:0] declination;
  logic signed [chd_pkg::DeclW-1:0] declination_next;
  logic                             pipe_en;
  logic                             last_valid;
  logic [chd_pkg::HdgW-1:0]         last_heading;
  logic                             out_valid;
  logic [chd_pkg::HdgW-1:0]         out_heading;
  logic                             skid_valid;
  logic [chd_pkg::HdgW-1:0]         skid_heading;

  assign pipe_en      = !skid_valid;
  assign sample.ready = pipe_en;
  assign cfg.ready    = 1'b1;
  assign result.valid   = out_valid;
  assign result.heading = out_heading;

  // Saturate declination on write
  always_comb begin
    priority if (cfg.declination > chd_pkg::DeclMax) begin
      declination_next = chd_pkg::DeclMax;
    end else if (cfg.declination < -chd_pkg::DeclMax) begin
      declination_next = -chd_pkg::DeclMax;
    end else begin
      declination_next = cfg.declination;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      declination <= '0;
    end else if (cfg.valid && cfg.ready) begin
      declination <= declination_next;
    end
  end

  chd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (pipe_en),
    .in_valid  (sample.valid),
    .mag_x     (sample.mag_x),
    .mag_y     (sample.mag_y),
    .out_stage (chain[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    chd_cell #(
      .STAGE (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (pipe_en),
      .in_stage  (chain[g]),
      .out_stage (chain[g+1])
    );
  end

  chd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .en          (pipe_en),
    .in_stage    (chain[CORDIC_STAGES]),
    .declination (declination),
    .res_valid   (last_valid),
    .res_heading (last_heading)
  );

  // Output register with skid: drain the skid first, else take the pipeline result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || result.ready) begin
      out_valid <= last_valid;
    end else if (last_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (result.ready) begin
        out_heading <= skid_heading;
      end
    end else if (!out_valid || result.ready) begin
      out_heading <= last_heading;
    end else begin
      skid_heading <= last_heading;
    end
  end

endmodule

/* rtl/core/chd_checker.sv */
// Port-level checks of the compass heading block and their binding to the top level.
module chd_checker (
  input logic           clk,
  input logic           rst,
  chd_sample_if.sink    sample,
  chd_heading_if.source result,
  chd_decl_if.sink      cfg
);

  // Heading stays within one full turn
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.heading <= chd_pkg::HdgFull))
    else $error("heading beyond full turn");

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (result.valid && $stable(result.heading)))
    else $error("stalled result changed");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid after reset");

  // Input backpressure only while a result is waiting
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !sample.ready |-> (result.valid && cfg.ready))
    else $error("sample stalled with no pending result");

endmodule

bind compass_heading_atan2 chd_checker u_chd_checker (
  .clk    (clk),
  .rst    (rst),
  .sample (sample),
  .result (result),
  .cfg    (cfg)
);
